// ===== rtl/normal_cdf_and_inverse_core_assert.svh =====
// Assertion macros for the normal CDF core checker.
// Both sample on the rising edge of clk and are quiet while rst is high.
`ifndef NORMAL_CDF_AND_INVERSE_CORE_ASSERT_SVH
`define NORMAL_CDF_AND_INVERSE_CORE_ASSERT_SVH

// Same-cycle implication.
`define NCDF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NCDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ncdf_pkg.sv =====
package ncdf_pkg;

  // Internal fixed point: signed, 32 fraction bits, held within +-2^40.
  localparam int Q_W = 42;
  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_ONE = 42'sd4294967296;
  localparam q_t Q_LIM = 42'sd1099511627776;

  // Configuration port.
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 31;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_Z_MAX = CFG_IDX_W'(0);
  localparam cfg_idx_t REG_Z_EPS = CFG_IDX_W'(1);

  typedef struct packed {
    logic              func;
    logic signed [31:0] z_in;
    logic        [31:0] p_in;
  } in_t;

  typedef struct packed {
    logic        [31:0] prob_out;
    logic signed [31:0] z_out;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BIS_CHECK,
    S_CDF_START,
    S_W_WAIT,
    S_H_MUL,
    S_H_WAIT,
    S_L_MUL,
    S_L_WAIT,
    S_CDF_OUT,
    S_BIS_UPD,
    S_DONE
  } state_t;

  // Decimal coefficient scaled by 1e12, rounded to the nearest Q32 value.
  localparam longint CQ_MUL  = 1048576;
  localparam longint CQ_HALF = 122070312;
  localparam longint CQ_DEN  = 244140625;

  function automatic q_t cq(input longint n);
    return q_t'((n * CQ_MUL + CQ_HALF) / CQ_DEN);
  endfunction

  localparam int LOW_N  = 9;
  localparam int HIGH_N = 15;
  typedef logic [3:0] cidx_t;

  localparam q_t LOW_POLY [LOW_N] = '{
    cq(64'sd124818987),     -cq(64'sd1075204047),   cq(64'sd5198775019),
    -cq(64'sd19198292004),  cq(64'sd59054035642),   -cq(64'sd151968751364),
    cq(64'sd319152932694),  -cq(64'sd531923007300), cq(64'sd797884560593)
  };

  localparam q_t HIGH_POLY [HIGH_N] = '{
    -cq(64'sd45255659),     cq(64'sd152529290),     -cq(64'sd19538132),
    -cq(64'sd676904986),    cq(64'sd1390604284),    -cq(64'sd794620820),
    -cq(64'sd2034254874),   cq(64'sd6549791214),    -cq(64'sd10557625006),
    cq(64'sd11630447319),   -cq(64'sd9279453341),   cq(64'sd5353579108),
    -cq(64'sd2141268741),   cq(64'sd535310849),     cq(64'sd999936657524)
  };

  // Clamp a one-bit-wider sum to +-2^40.
  function automatic q_t sat_q(input logic signed [Q_W:0] v);
    if (v > Q_LIM) return Q_LIM;
    if (v < -Q_LIM) return -Q_LIM;
    return q_t'(v[Q_W-1:0]);
  endfunction

endpackage

// ===== rtl/ncdf_mul.sv =====
// Sequential Q32 multiplier: four 32x32 partial products, one per cycle.
// Magnitude product truncated to Q32, clamped to 2^40, then signed.
module ncdf_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ncdf_pkg::q_t  a,
  input  ncdf_pkg::q_t  b,
  output logic          done,
  output ncdf_pkg::q_t  res
);

  localparam int MAG_W  = ncdf_pkg::Q_W - 1;
  localparam int PROD_W = 2 * MAG_W - 1;
  localparam int HI_W   = PROD_W - 32;

  localparam logic [2:0] PH_LAST_MUL = 3'd3;
  localparam logic [2:0] PH_FINAL    = 3'd5;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_64 = 2'd2;

  localparam logic [HI_W-1:0] LIM_U = HI_W'(ncdf_pkg::Q_LIM);

  logic [MAG_W-1:0]  ua;
  logic [MAG_W-1:0]  ub;
  logic              neg;
  logic              run;
  logic [2:0]        ph;
  logic [63:0]       pp;
  logic              pp_v;
  logic [1:0]        pp_sh;
  logic [PROD_W-1:0] acc;

  ncdf_pkg::q_t      abs_a;
  ncdf_pkg::q_t      abs_b;
  logic [31:0]       op_a;
  logic [31:0]       op_b;
  logic [1:0]        op_sh;
  logic [PROD_W-1:0] pp_ext;
  logic [HI_W-1:0]   r_hi;
  logic [MAG_W-1:0]  mag;

  assign abs_a = a[ncdf_pkg::Q_W-1] ? -a : a;
  assign abs_b = b[ncdf_pkg::Q_W-1] ? -b : b;

  always_comb begin
    case (ph)
      3'd0: begin
        op_a = ua[31:0];
        op_b = ub[31:0];
        op_sh = SH_0;
      end
      3'd1: begin
        op_a = ua[31:0];
        op_b = 32'(ub[MAG_W-1:32]);
        op_sh = SH_32;
      end
      3'd2: begin
        op_a = 32'(ua[MAG_W-1:32]);
        op_b = ub[31:0];
        op_sh = SH_32;
      end
      3'd3: begin
        op_a = 32'(ua[MAG_W-1:32]);
        op_b = 32'(ub[MAG_W-1:32]);
        op_sh = SH_64;
      end
      default: begin
        op_a = 32'd0;
        op_b = 32'd0;
        op_sh = SH_0;
      end
    endcase
  end

  always_comb begin
    case (pp_sh)
      SH_32:   pp_ext = PROD_W'(pp) << 32;
      SH_64:   pp_ext = PROD_W'(pp) << 64;
      default: pp_ext = PROD_W'(pp);
    endcase
  end

  assign r_hi = acc[PROD_W-1:32];
  assign mag  = (r_hi > LIM_U) ? MAG_W'(LIM_U) : r_hi[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      pp_v <= 1'b0;
      ph   <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ua   <= abs_a[MAG_W-1:0];
        ub   <= abs_b[MAG_W-1:0];
        neg  <= a[ncdf_pkg::Q_W-1] ^ b[ncdf_pkg::Q_W-1];
        acc  <= '0;
        run  <= 1'b1;
        ph   <= 3'd0;
        pp_v <= 1'b0;
      end else if (run) begin
        pp    <= 64'(op_a) * 64'(op_b);
        pp_sh <= op_sh;
        pp_v  <= (ph <= PH_LAST_MUL);
        if (pp_v) begin
          acc <= acc + pp_ext;
        end
        if (ph == PH_FINAL) begin
          res  <= neg ? -ncdf_pkg::q_t'({1'b0, mag}) : ncdf_pkg::q_t'({1'b0, mag});
          done <= 1'b1;
          run  <= 1'b0;
        end
        ph <= ph + 3'd1;
      end
    end
  end

endmodule

// ===== rtl/normal_cdf_and_inverse_core.sv =====
// Standard normal CDF and inverse CDF core. Each request carries func: 0 returns
// prob_out = Phi(z_in) in Q1.31 (2^31 is one), 1 returns z_out with Phi(z_out)
// near p_in, found by bisection on [-z_max, z_max] (Q4.27). Every request gives
// exactly one result; the unused output field reads zero. The CDF runs a Horner
// polynomial on one shared multiplier, with one branch for |z| below 2 and one
// for |z| of 2 and above; z zero or saturated skips the polynomial. The next
// request can be taken in the cycle after a result is loaded. An inverse request
// probes z = 0 first, then runs one CDF probe per bisection step and narrows the
// interval until it is no wider than the stop width or MAX_BISECT_STEPS steps
// have run. p outside (0,1) skips the search and returns z = 0. in_stall stays
// high for the whole computation; the result sits in an output register, so a
// new request is taken while an earlier result waits on out_stall.
// Configuration: write z_max at index 0 and the bisection stop width at index 1
// (31 bits each) while no request is in flight; other indexes are ignored.
module normal_cdf_and_inverse_core #(
  parameter int MAX_BISECT_STEPS = 32,
  parameter int Z_FRAC_BITS      = 27
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ncdf_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ncdf_pkg::out_t            out_data,
  input  logic                      cfg_we,
  input  ncdf_pkg::cfg_idx_t        cfg_index,
  input  logic [ncdf_pkg::CFG_W-1:0] cfg_data
);

  // Shift that turns |z| into y = |z|/2 with 32 fraction bits.
  localparam int Y_SH   = 31 - Z_FRAC_BITS;
  localparam int Y_W    = 32 + Y_SH;
  localparam int STEP_W = $clog2(MAX_BISECT_STEPS + 1);

  localparam logic [ncdf_pkg::CFG_W-1:0] Z_MAX_RST = 31'd805306368;
  localparam logic [ncdf_pkg::CFG_W-1:0] Z_EPS_RST = 31'd134;

  ncdf_pkg::state_t state;
  ncdf_pkg::state_t state_next;

  // Configuration registers.
  logic [ncdf_pkg::CFG_W-1:0] z_max;
  logic [ncdf_pkg::CFG_W-1:0] z_eps;

  // Request and bisection registers.
  logic               func_r;
  logic [31:0]        p_r;
  logic signed [31:0] cz;
  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic [STEP_W-1:0]  steps;
  logic [31:0]        prob_r;
  logic signed [31:0] res_z;

  // Polynomial registers.
  ncdf_pkg::q_t  acc;
  ncdf_pkg::q_t  tv;
  ncdf_pkg::q_t  ylow;
  ncdf_pkg::q_t  xv;
  logic          hi_br;
  ncdf_pkg::cidx_t cidx;

  // Shared multiplier.
  logic          mul_start;
  ncdf_pkg::q_t  mul_a;
  ncdf_pkg::q_t  mul_b;
  logic          mul_done;
  ncdf_pkg::q_t  mul_res;

  logic               accept;
  logic               out_load;
  logic               p_bad;
  logic signed [32:0] az33;
  logic [31:0]        az;
  logic               z_zero;
  logic               z_sat;
  logic [Y_W-1:0]     y;
  logic               y_lt_one;
  ncdf_pkg::q_t       y_q;
  logic signed [63:0] t_full;
  ncdf_pkg::q_t       t_q;
  ncdf_pkg::q_t       coef;
  logic               poly_last;
  ncdf_pkg::q_t       acc_next;
  ncdf_pkg::q_t       x_low;
  logic signed [42:0] v43;
  logic [31:0]        prob_calc;
  logic signed [32:0] sum33;
  logic signed [32:0] span;
  logic signed [31:0] mid;
  logic               go_on;

  ncdf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign accept = in_valid && !in_stall;
  assign p_bad  = (in_data.p_in == 32'd0) || in_data.p_in[31];

  // CDF front end: |z|, the zero and saturation cases, y and t.
  assign az33     = cz[31] ? -{cz[31], cz} : {cz[31], cz};
  assign az       = az33[31:0];
  assign z_zero   = (cz == 32'sd0);
  assign z_sat    = (az >= {1'b0, z_max});
  assign y        = Y_W'(az) << Y_SH;
  assign y_lt_one = (y[Y_W-1:32] == '0);
  assign y_q      = ncdf_pkg::q_t'(y[31:0]);
  assign t_full   = $signed(64'(y)) - 64'sd8589934592;
  assign t_q      = (t_full > 64'(ncdf_pkg::Q_LIM)) ? ncdf_pkg::Q_LIM
                                                    : ncdf_pkg::q_t'(t_full);

  // Horner step: acc * tv (t, or w for the low branch) + next coefficient, clamped.
  always_comb begin
    if (hi_br) begin
      coef      = ncdf_pkg::HIGH_POLY[cidx];
      poly_last = (cidx == ncdf_pkg::cidx_t'(ncdf_pkg::HIGH_N - 1));
    end else begin
      coef      = ncdf_pkg::LOW_POLY[cidx];
      poly_last = (cidx == ncdf_pkg::cidx_t'(ncdf_pkg::LOW_N - 1));
    end
  end

  assign acc_next = ncdf_pkg::sat_q({mul_res[ncdf_pkg::Q_W-1], mul_res} +
                                    {coef[ncdf_pkg::Q_W-1], coef});
  assign x_low    = ncdf_pkg::sat_q({mul_res, 1'b0});

  // Mirror by sign, round half up to Q1.31, clamp to [0, 1].
  always_comb begin
    if (!cz[31] && !z_zero) begin
      v43 = 43'sd4294967296 + {xv[ncdf_pkg::Q_W-1], xv} + 43'sd2;
    end else begin
      v43 = 43'sd4294967296 - {xv[ncdf_pkg::Q_W-1], xv} + 43'sd2;
    end
    if (v43[42]) begin
      prob_calc = 32'd0;
    end else if (v43[42:2] > 41'd2147483648) begin
      prob_calc = 32'h8000_0000;
    end else begin
      prob_calc = v43[33:2];
    end
  end

  // Bisection: midpoint rounds toward minus infinity.
  assign sum33 = {lo[31], lo} + {hi[31], hi};
  assign mid   = sum33[32:1];
  assign span  = {hi[31], hi} - {lo[31], lo};
  assign go_on = (span > $signed({2'b00, z_eps})) &&
                 (steps < STEP_W'(MAX_BISECT_STEPS));

  always_comb begin
    state_next = state;
    case (state)
      ncdf_pkg::S_IDLE: begin
        if (in_valid) begin
          if (!in_data.func) begin
            state_next = ncdf_pkg::S_CDF_START;
          end else if (p_bad) begin
            state_next = ncdf_pkg::S_DONE;
          end else begin
            state_next = ncdf_pkg::S_BIS_CHECK;
          end
        end
      end
      ncdf_pkg::S_BIS_CHECK: begin
        state_next = go_on ? ncdf_pkg::S_CDF_START : ncdf_pkg::S_DONE;
      end
      ncdf_pkg::S_CDF_START: begin
        if (z_zero || z_sat) begin
          state_next = ncdf_pkg::S_CDF_OUT;
        end else if (y_lt_one) begin
          state_next = ncdf_pkg::S_W_WAIT;
        end else begin
          state_next = ncdf_pkg::S_H_MUL;
        end
      end
      ncdf_pkg::S_W_WAIT: begin
        if (mul_done) state_next = ncdf_pkg::S_H_MUL;
      end
      ncdf_pkg::S_H_MUL: begin
        state_next = ncdf_pkg::S_H_WAIT;
      end
      ncdf_pkg::S_H_WAIT: begin
        if (mul_done) begin
          if (!poly_last) begin
            state_next = ncdf_pkg::S_H_MUL;
          end else if (hi_br) begin
            state_next = ncdf_pkg::S_CDF_OUT;
          end else begin
            state_next = ncdf_pkg::S_L_MUL;
          end
        end
      end
      ncdf_pkg::S_L_MUL: begin
        state_next = ncdf_pkg::S_L_WAIT;
      end
      ncdf_pkg::S_L_WAIT: begin
        if (mul_done) state_next = ncdf_pkg::S_CDF_OUT;
      end
      ncdf_pkg::S_CDF_OUT: begin
        state_next = func_r ? ncdf_pkg::S_BIS_UPD : ncdf_pkg::S_DONE;
      end
      ncdf_pkg::S_BIS_UPD: begin
        state_next = ncdf_pkg::S_BIS_CHECK;
      end
      ncdf_pkg::S_DONE: begin
        if (!out_valid || !out_stall) state_next = ncdf_pkg::S_IDLE;
      end
      default: begin
        state_next = ncdf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    mul_start = 1'b0;
    mul_a     = acc;
    mul_b     = tv;
    out_load  = 1'b0;
    case (state)
      ncdf_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      ncdf_pkg::S_CDF_START: begin
        // w = y * y for the low branch
        mul_start = !z_zero && !z_sat && y_lt_one;
        mul_a     = y_q;
        mul_b     = y_q;
      end
      ncdf_pkg::S_H_MUL: begin
        mul_start = 1'b1;
      end
      ncdf_pkg::S_L_MUL: begin
        mul_start = 1'b1;
        mul_b     = ylow;
      end
      ncdf_pkg::S_DONE: begin
        out_load = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncdf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers: keep only the listed indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      z_max <= Z_MAX_RST;
      z_eps <= Z_EPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ncdf_pkg::REG_Z_MAX: z_max <= cfg_data;
        ncdf_pkg::REG_Z_EPS: z_eps <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ncdf_pkg::S_IDLE: begin
        if (accept) begin
          func_r <= in_data.func;
          p_r    <= in_data.p_in;
          cz     <= in_data.z_in;
          lo     <= -$signed({1'b0, z_max});
          hi     <= $signed({1'b0, z_max});
          steps  <= '0;
          res_z  <= 32'sd0;
          prob_r <= 32'd0;
        end
      end
      ncdf_pkg::S_BIS_CHECK: begin
        // probe the midpoint, or return it once the interval is closed
        if (go_on) begin
          cz <= mid;
        end else begin
          res_z <= mid;
        end
      end
      ncdf_pkg::S_CDF_START: begin
        ylow  <= y_q;
        hi_br <= !y_lt_one;
        tv    <= t_q;
        acc   <= ncdf_pkg::HIGH_POLY[0];
        cidx  <= ncdf_pkg::cidx_t'(1);
        if (z_zero) begin
          xv <= '0;
        end else if (z_sat) begin
          xv <= ncdf_pkg::Q_ONE;
        end
      end
      ncdf_pkg::S_W_WAIT: begin
        if (mul_done) begin
          tv   <= mul_res;
          acc  <= ncdf_pkg::LOW_POLY[0];
          cidx <= ncdf_pkg::cidx_t'(1);
        end
      end
      ncdf_pkg::S_H_WAIT: begin
        if (mul_done) begin
          acc  <= acc_next;
          cidx <= cidx + ncdf_pkg::cidx_t'(1);
          if (poly_last && hi_br) xv <= acc_next;
        end
      end
      ncdf_pkg::S_L_WAIT: begin
        if (mul_done) xv <= x_low;
      end
      ncdf_pkg::S_CDF_OUT: begin
        prob_r <= prob_calc;
      end
      ncdf_pkg::S_BIS_UPD: begin
        // narrow toward p
        if (prob_r > p_r) begin
          hi <= cz;
        end else begin
          lo <= cz;
        end
        steps <= steps + STEP_W'(1);
      end
      default: ;
    endcase
  end

  // Output register: hold the result until the consumer drops out_stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.prob_out <= func_r ? 32'd0 : prob_r;
      out_data.z_out    <= func_r ? res_z : 32'sd0;
    end
  end

endmodule

// ===== rtl/ncdf_checker.sv =====
`include "normal_cdf_and_inverse_core_assert.svh"

module ncdf_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input ncdf_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input ncdf_pkg::out_t out_data
);

  // A result waiting on the consumer holds.
  `NCDF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // One request at a time: after a request the core stalls its input.
  `NCDF_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall && (in_data.func || !in_data.func), in_stall, "request taken while busy")

  // Only one field of a result carries a value.
  `NCDF_ASSERT_IMPL(a_one_field, out_valid, out_data.prob_out == 32'd0 || out_data.z_out == 32'sd0, "both result fields set")

  // A probability never exceeds one.
  `NCDF_ASSERT_IMPL(a_prob_range, out_valid, out_data.prob_out <= 32'h8000_0000, "probability above one")

endmodule

bind normal_cdf_and_inverse_core ncdf_checker u_ncdf_checker (.*);

// ===== verif/tb_normal_cdf_and_inverse_core.sv =====
module tb_normal_cdf_and_inverse_core;

  // Block parameters, kept in step with the instance below.
  localparam int BISECT_CAP = 32;
  localparam int ZF_BITS    = 27;

  // Operation codes carried in the func field of a request.
  localparam logic OP_CDF = 1'b0;
  localparam logic OP_INV = 1'b1;

  // An index that maps to no register; writes to it must be dropped.
  localparam ncdf_pkg::cfg_idx_t REG_UNMAPPED = ncdf_pkg::CFG_IDX_W'(8'hA5);

  // Reset values of the two registers.
  localparam logic [ncdf_pkg::CFG_W-1:0] Z_MAX_RESET = 31'd805306368;
  localparam logic [ncdf_pkg::CFG_W-1:0] Z_EPS_RESET = 31'd134;

  // Q32 and Q1.31 helpers for the prediction.
  localparam longint ONE_Q = 64'sd4294967296;
  localparam longint LIM_Q = 64'sd1099511627776;
  localparam longint P_ONE = 64'sd2147483648;

  // Decimal coefficients scaled by 1e12, highest power first.
  localparam longint LOW_SCALED [9] = '{
    64'sd124818987, -64'sd1075204047, 64'sd5198775019,
    -64'sd19198292004, 64'sd59054035642, -64'sd151968751364,
    64'sd319152932694, -64'sd531923007300, 64'sd797884560593
  };
  localparam longint HIGH_SCALED [15] = '{
    -64'sd45255659, 64'sd152529290, -64'sd19538132, -64'sd676904986,
    64'sd1390604284, -64'sd794620820, -64'sd2034254874,
    64'sd6549791214, -64'sd10557625006, 64'sd11630447319,
    -64'sd9279453341, 64'sd5353579108, -64'sd2141268741,
    64'sd535310849, 64'sd999936657524
  };

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  ncdf_pkg::in_t                 in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  ncdf_pkg::out_t                out_data;
  logic                          cfg_we    = 1'b0;
  ncdf_pkg::cfg_idx_t            cfg_index = ncdf_pkg::REG_Z_MAX;
  logic [ncdf_pkg::CFG_W-1:0]    cfg_data  = '0;

  // Register copies used by the prediction.
  logic [ncdf_pkg::CFG_W-1:0] z_max_now = Z_MAX_RESET;
  logic [ncdf_pkg::CFG_W-1:0] z_eps_now = Z_EPS_RESET;

  longint low_coef  [9];
  longint high_coef [15];

  ncdf_pkg::in_t  pending_requests [$];
  ncdf_pkg::out_t awaited_results  [$];
  ncdf_pkg::out_t oldest_result;

  int   mismatch_count = 0;
  bit   idle_on        = 1'b1;
  bit   request_taken  = 1'b0;
  bit   result_taken   = 1'b0;
  int   send_gap       = 0;
  int   stall_left     = 3;

  ncdf_pkg::in_t next_req;
  logic          next_valid = 1'b0;
  logic          next_stall;

  normal_cdf_and_inverse_core #(
    .MAX_BISECT_STEPS(BISECT_CAP),
    .Z_FRAC_BITS     (ZF_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Fixed-point prediction
  // ---------------------------------------------------------------------

  // Round a 1e12-scaled decimal to the nearest Q32 value, sign applied last.
  function automatic longint q32_of(input longint n);
    if (n < 0) return -((-n * 64'sd1048576 + 64'sd122070312) / 64'sd244140625);
    return (n * 64'sd1048576 + 64'sd122070312) / 64'sd244140625;
  endfunction

  function automatic longint clamp_q(input longint v);
    if (v > LIM_Q) return LIM_Q;
    if (v < -LIM_Q) return -LIM_Q;
    return v;
  endfunction

  // Exact product, magnitude truncated to Q32, then clamped.
  function automatic longint qmul(input longint a, input longint b);
    bit           neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] prod;
    longint       r;
    neg  = (a < 0) != (b < 0);
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    prod = ua * ub;
    r    = longint'(prod >> 32);
    if (r > LIM_Q) r = LIM_Q;
    return neg ? -r : r;
  endfunction

  function automatic longint horner_eval(input bit use_high, input longint t);
    int     n;
    longint acc;
    n   = use_high ? 15 : 9;
    acc = use_high ? high_coef[0] : low_coef[0];
    for (int i = 1; i < n; i++)
      acc = clamp_q(qmul(acc, t) + (use_high ? high_coef[i] : low_coef[i]));
    return acc;
  endfunction

  // Phi(z) in Q1.31 for a z with ZF_BITS fraction bits.
  function automatic logic [31:0] phi_q31(input longint z);
    longint az;
    longint x;
    longint y;
    longint v;
    az = (z < 0) ? -z : z;
    if (z == 0) begin
      x = 0;
    end else if (az >= longint'(z_max_now)) begin
      x = ONE_Q;
    end else begin
      y = az <<< (31 - ZF_BITS);
      if (y < ONE_Q) x = clamp_q(2 * qmul(horner_eval(1'b0, qmul(y, y)), y));
      else x = horner_eval(1'b1, clamp_q(y - 2 * ONE_Q));
    end
    v = (z > 0) ? (ONE_Q + x + 2) : (ONE_Q - x + 2);
    if (v < 0) return 32'd0;
    v = v >>> 2;
    if (v > P_ONE) v = P_ONE;
    return 32'(v);
  endfunction

  // Bisection for the z whose Phi lands near p.
  function automatic longint phi_inverse(input logic [31:0] p);
    longint lo;
    longint hi;
    longint z;
    int     steps;
    lo    = -longint'(z_max_now);
    hi    = longint'(z_max_now);
    z     = 0;
    steps = 0;
    if (p == 32'd0 || p >= 32'h8000_0000) return 0;
    while (hi - lo > longint'(z_eps_now) && steps < BISECT_CAP) begin
      if (phi_q31(z) > p) hi = z;
      else lo = z;
      z = ((lo + hi + 2 * ONE_Q) >>> 1) - ONE_Q;
      steps++;
    end
    return z;
  endfunction

  function automatic ncdf_pkg::out_t compute_result(input ncdf_pkg::in_t req);
    ncdf_pkg::out_t r;
    longint         zz;
    r = '0;
    if (req.func == OP_CDF) begin
      r.prob_out = phi_q31(longint'($signed(req.z_in)));
    end else begin
      zz      = phi_inverse(req.p_in);
      r.z_out = 32'(zz);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Queue a CDF request; fill the unused probability with noise.
  task automatic push_cdf(input logic signed [31:0] z);
    ncdf_pkg::in_t r;
    r.func = OP_CDF;
    r.z_in = z;
    r.p_in = $urandom;
    pending_requests.push_back(r);
  endtask

  // Queue an inverse request; fill the unused z with noise.
  task automatic push_inv(input logic [31:0] p);
    ncdf_pkg::in_t r;
    r.func = OP_INV;
    r.z_in = $urandom;
    r.p_in = p;
    pending_requests.push_back(r);
  endtask

  // Mostly CDF requests, aimed at zero, the branch boundary at |z| = 2,
  // the saturation bound and the span up to just past it; inverse requests mostly
  // with p inside (0,1), some at or beyond the ends.
  function automatic ncdf_pkg::in_t random_request();
    ncdf_pkg::in_t r;
    int unsigned   sel;
    int unsigned   u;
    longint        mag;
    longint        span;
    bit            neg;
    bit            keep_raw;
    r.func   = ($urandom_range(0, 99) < 30) ? OP_INV : OP_CDF;
    r.z_in   = $urandom;
    r.p_in   = $urandom;
    neg      = $urandom_range(0, 1);
    keep_raw = 1'b0;
    mag      = 0;
    if (r.func == OP_CDF) begin
      sel  = $urandom_range(0, 9);
      span = longint'(z_max_now) + longint'(z_max_now) / 8 + 1;
      if (span > 64'sd2147483647) span = 64'sd2147483647;
      case (sel)
        0: keep_raw = 1'b1;
        1: mag = longint'($urandom_range(0, 32'h0FFF_FFFF));
        2: begin
          u   = $urandom_range(0, 64);
          mag = 64'sd268435456 + longint'(u) - 32;
        end
        3: begin
          u   = $urandom_range(0, 32);
          mag = longint'(z_max_now) + longint'(u) - 16;
          if (mag < 0) mag = 0;
        end
        4: mag = 0;
        default: mag = longint'($urandom_range(0, 32'(span)));
      endcase
      if (!keep_raw) r.z_in = neg ? 32'(-mag) : 32'(mag);
    end else begin
      sel = $urandom_range(0, 15);
      case (sel)
        0: r.p_in = 32'd0;
        1: r.p_in = 32'h8000_0000;
        2: r.p_in = $urandom;
        3: r.p_in = $urandom_range(1, 1000);
        4: r.p_in = 32'h8000_0000 - $urandom_range(1, 1000);
        default: r.p_in = $urandom_range(1, 32'h7FFF_FFFF);
      endcase
    end
    return r;
  endfunction

  task automatic add_random(input int count);
    for (int i = 0; i < count; i++) pending_requests.push_back(random_request());
  endtask

  // Hold until every queued request is taken and every result is back.
  task automatic wait_until_quiet();
    while (pending_requests.size() != 0 || in_valid || next_valid ||
           awaited_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One-cycle register write; mirror it into the prediction copy.
  task automatic write_reg(input ncdf_pkg::cfg_idx_t idx,
                           input logic [ncdf_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    if (idx == ncdf_pkg::REG_Z_MAX) z_max_now = val;
    else if (idx == ncdf_pkg::REG_Z_EPS) z_eps_now = val;
  endtask

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Note each accepted request and queue its predicted result.
  always @(posedge clk) begin
    request_taken = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      request_taken = 1'b1;
      awaited_results.push_back(compute_result(in_data));
    end
  end

  // Drive requests at the falling edge. Drop valid once taken, idle for the
  // drawn gap, then present the next request. Valid and data get one
  // assignment per edge, so back-to-back requests keep valid high.
  always @(negedge clk) begin
    next_valid = in_valid;
    next_req   = in_data;
    if (in_valid && request_taken) next_valid = 1'b0;
    if (!next_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_requests.size() != 0) begin
        next_req   = pending_requests.pop_front();
        next_valid = 1'b1;
        send_gap   = idle_on ? $urandom_range(0, 7) : 0;
      end
    end
    in_valid <= next_valid;
    in_data  <= next_req;
  end

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    result_taken = 1'b0;
    if (!rst && out_valid && !out_stall) begin
      result_taken = 1'b1;
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: prob_out %0d z_out %0d",
               out_data.prob_out, $signed(out_data.z_out));
        mismatch_count++;
      end else begin
        oldest_result = awaited_results.pop_front();
        if (out_data.prob_out !== oldest_result.prob_out) begin
          $error("prob_out: expected %0d, got %0d",
                 oldest_result.prob_out, out_data.prob_out);
          mismatch_count++;
        end
        if (out_data.z_out !== oldest_result.z_out) begin
          $error("z_out: expected %0d, got %0d",
                 $signed(oldest_result.z_out), $signed(out_data.z_out));
          mismatch_count++;
        end
      end
    end
  end

  // Stall each waiting result for a drawn number of cycles; toggle stall
  // now and then while nothing waits, too.
  always @(negedge clk) begin
    if (result_taken) stall_left = idle_on ? $urandom_range(0, 7) : 0;
    if (out_valid) begin
      if (stall_left > 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
    end else begin
      next_stall = idle_on && ($urandom_range(0, 3) == 0);
    end
    out_stall <= next_stall;
  end

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    for (int i = 0; i < 9; i++) low_coef[i] = q32_of(LOW_SCALED[i]);
    for (int i = 0; i < 15; i++) high_coef[i] = q32_of(HIGH_SCALED[i]);

    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Reset register values. Zero, the smallest steps, both full-scale
    // ends, the saturation bound and either side of |z| = 2.
    push_cdf(32'sd0);
    push_cdf(32'sd1);
    push_cdf(-32'sd1);
    push_cdf(32'sh7FFF_FFFF);
    push_cdf(32'sh8000_0000);
    push_cdf(32'sd805306368);
    push_cdf(32'sd805306367);
    push_cdf(-32'sd805306367);
    push_cdf(32'sd268435456);
    push_cdf(32'sd268435455);
    push_cdf(-32'sd268435456);
    push_cdf(32'sd134217728);
    push_cdf(-32'sd134217728);
    push_cdf(32'sd402653184);
    // Probability zero, one, beyond one, and a few inside.
    push_inv(32'd0);
    push_inv(32'h8000_0000);
    push_inv(32'hFFFF_FFFF);
    push_inv(32'd1);
    push_inv(32'h7FFF_FFFF);
    push_inv(32'h4000_0000);
    push_inv(32'h6CCC_CCCC);
    push_inv(32'h1333_3333);
    wait_until_quiet();

    // Widest bound with a stop width of one; the stray write is dropped.
    write_reg(ncdf_pkg::REG_Z_MAX, 31'h7FFF_FFFF);
    write_reg(ncdf_pkg::REG_Z_EPS, 31'd1);
    write_reg(REG_UNMAPPED, 31'($urandom));
    add_random(110);
    wait_until_quiet();

    // Zero bound and the widest stop width: every CDF request with nonzero z saturates.
    write_reg(ncdf_pkg::REG_Z_MAX, 31'd0);
    write_reg(ncdf_pkg::REG_Z_EPS, 31'h7FFF_FFFF);
    add_random(30);
    wait_until_quiet();

    // Default bound with zero stop width: bisection runs until the interval closes or to the step cap.
    write_reg(ncdf_pkg::REG_Z_MAX, Z_MAX_RESET);
    write_reg(ncdf_pkg::REG_Z_EPS, 31'd0);
    add_random(60);
    wait_until_quiet();

    // Two random settings.
    write_reg(ncdf_pkg::REG_Z_MAX, 31'($urandom_range(32'h0800_0000, 32'h7FFF_FFFF)));
    write_reg(ncdf_pkg::REG_Z_EPS, 31'($urandom_range(1, 32'h0010_0000)));
    add_random(75);
    wait_until_quiet();

    write_reg(ncdf_pkg::REG_Z_MAX, 31'($urandom_range(1, 32'h1000_0000)));
    write_reg(ncdf_pkg::REG_Z_EPS, 31'($urandom_range(1, 32'h0000_4000)));
    add_random(75);
    wait_until_quiet();

    // Back to reset values: first a stretch with no idling on either side.
    write_reg(ncdf_pkg::REG_Z_MAX, Z_MAX_RESET);
    write_reg(ncdf_pkg::REG_Z_EPS, Z_EPS_RESET);
    idle_on = 1'b0;
    add_random(80);
    wait_until_quiet();
    idle_on = 1'b1;
    add_random(90);
    wait_until_quiet();

    // Allow a full inverse latency for any stray result to show up.
    repeat (4000) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #200000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== normal_cdf_and_inverse_core.f =====
+incdir+rtl
rtl/ncdf_pkg.sv
rtl/ncdf_mul.sv
rtl/normal_cdf_and_inverse_core.sv
rtl/ncdf_checker.sv
verif/tb_normal_cdf_and_inverse_core.sv
